[hw/rtl/rss_pkg.sv]
// shared types and codes for the ranked sorted set
package rss_pkg;

    localparam int RANK_IN_BITS  = 10;
    localparam int RANK_OUT_BITS = 11;
    localparam int STATUS_BITS   = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } rss_ctl_t;

endpackage

[hw/rtl/rss_cell.sv]
// one storage cell of the sorted chain: holds a key, compares it, shifts with its neighbors
module rss_cell #(
    parameter int IDX      = 0,
    parameter int KEY_BITS = 17,
    parameter int CW       = 11
) (
    input  logic                                clk,
    input  rss_pkg::rss_ctl_t                   ctl,
    input  logic [KEY_BITS-1:0]                 cmd_key,
    input  logic [CW-1:0]                       pos,
    input  logic [rss_pkg::RANK_IN_BITS-1:0]    rank,
    input  logic [CW-1:0]                       count,
    input  logic [KEY_BITS-1:0]                 left_key,
    input  logic [KEY_BITS-1:0]                 right_key,
    output logic [KEY_BITS-1:0]                 key_q,
    output logic                                gt,
    output logic                                eq
);

    localparam int XW = CW + rss_pkg::RANK_IN_BITS;
    localparam logic [XW-1:0] IDX_W = XW'(IDX);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                occupied;

    assign occupied = IDX_W < XW'(count);
    assign gt       = occupied && (key_reg > cmd_key);
    assign eq       = occupied && (key_reg == cmd_key);
    assign key_q    = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins_en)
        begin
            if (IDX_W == XW'(pos))
                key_next = cmd_key;
            else if (IDX_W > XW'(pos))
                key_next = left_key;
        end
        else if (ctl.rem_en)
        begin
            if (IDX_W >= XW'(rank))
                key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

[hw/rtl/rss_count_tree.sv]
// registered reduction tree: counts greater keys and detects an equal key
module rss_count_tree #(
    parameter int LEAVES = 1024,
    parameter int CW     = 11
) (
    input  logic              clk,
    input  logic [LEAVES-1:0] gt,
    input  logic [LEAVES-1:0] eq,
    output logic [CW-1:0]     count,
    output logic              found
);

    localparam int P = 1 << $clog2(LEAVES);

    logic [P-1:0]  gt_pad;
    logic [P-1:0]  eq_pad;
    logic [CW-1:0] cnt_reg [1:2*P-1];
    logic          eq_reg  [1:2*P-1];

    assign gt_pad = P'(gt);
    assign eq_pad = P'(eq);

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < P; j++)
        begin
            cnt_reg[P+j] <= CW'(gt_pad[j]);
            eq_reg[P+j]  <= eq_pad[j];
        end
        for (int j = 1; j < P; j++)
        begin
            cnt_reg[j] <= CW'(cnt_reg[2*j] + cnt_reg[2*j+1]);
            eq_reg[j]  <= eq_reg[2*j] | eq_reg[2*j+1];
        end
    end

    assign count = cnt_reg[1];
    assign found = eq_reg[1];

endmodule

[hw/rtl/ranked_sorted_set_core.sv]
// top level of the ranked sorted set: command control, cell chain and count tree
//
// keeps up to CAPACITY distinct keys in descending order, rank 0 largest.
// command channel: a transaction is taken at a clock edge with start high and
// busy low; op selects insert (key) or remove (rank_in). busy stays high until
// the command's result is out.
// result channel: done is high for exactly one cycle with rank_out and status;
// the receiver cannot stall, so results are never held back.
// insert: rank_out is the count of stored keys greater than key; status flags
// a duplicate or a full store, in which case nothing is stored.
// remove: rank_out echoes rank_in; an out-of-range rank is flagged and ignored.
// an insert waits in a count state while the registered count tree sums the
// compare flags of all cells; a remove goes straight to the apply state.
// busy falls in the cycle done rises, so the next command may start then.
// reset empties the set; stored key values are not cleared.
module ranked_sorted_set_core #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 17
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic [KEY_BITS-1:0]                   key,
    input  logic [rss_pkg::RANK_IN_BITS-1:0]      rank_in,
    output logic                                  done,
    output logic [rss_pkg::RANK_OUT_BITS-1:0]     rank_out,
    output logic [rss_pkg::STATUS_BITS-1:0]       status
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int LEVELS = $clog2(CAPACITY);
    localparam int WAIT   = LEVELS + 1;
    localparam int WW     = $clog2(WAIT + 1);
    localparam int XW     = CW + rss_pkg::RANK_IN_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COUNT = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]                           state_reg, state_next;
    logic [WW-1:0]                        wait_reg, wait_next;
    logic                                 op_reg;
    logic [KEY_BITS-1:0]                  cmd_key_reg;
    logic [rss_pkg::RANK_IN_BITS-1:0]     rank_reg;
    logic [CW-1:0]                        count_reg, count_next;
    logic                                 done_reg, done_next;
    logic [rss_pkg::RANK_OUT_BITS-1:0]    rank_out_reg, rank_out_next;
    logic [rss_pkg::STATUS_BITS-1:0]      status_reg, status_next;
    rss_pkg::rss_ctl_t                    ctl;
    logic                                 accept;

    logic [KEY_BITS-1:0] key_q [CAPACITY];
    logic [CAPACITY-1:0] gt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CW-1:0]       pos;
    logic                found;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = state_reg != S_IDLE;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            rss_cell #(
                .IDX      (i),
                .KEY_BITS (KEY_BITS),
                .CW       (CW)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .cmd_key   (cmd_key_reg),
                .pos       (pos),
                .rank      (rank_reg),
                .count     (count_reg),
                .left_key  ((i == 0) ? cmd_key_reg : key_q[(i == 0) ? 0 : i-1]),
                .right_key (key_q[(i == CAPACITY-1) ? i : i+1]),
                .key_q     (key_q[i]),
                .gt        (gt_vec[i]),
                .eq        (eq_vec[i])
            );
        end
    endgenerate

    rss_count_tree #(
        .LEAVES (CAPACITY),
        .CW     (CW)
    ) u_tree (
        .clk   (clk),
        .gt    (gt_vec),
        .eq    (eq_vec),
        .count (pos),
        .found (found)
    );

    always_comb
    begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        rank_out_next = rank_out_reg;
        status_next   = status_reg;
        ctl.ins_en    = 1'b0;
        ctl.rem_en    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    wait_next  = '0;
                    state_next = (op == rss_pkg::OP_REMOVE) ? S_APPLY : S_COUNT;
                end
            end
            S_COUNT:
            begin
                wait_next = WW'(wait_reg + 1'b1);
                if (wait_reg == WW'(WAIT - 1))
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (op_reg == rss_pkg::OP_INSERT)
                begin
                    rank_out_next = rss_pkg::RANK_OUT_BITS'(pos);
                    if (found)
                        status_next = rss_pkg::ST_DUP;
                    else if (count_reg >= CW'(CAPACITY))
                        status_next = rss_pkg::ST_FULL;
                    else
                    begin
                        status_next = rss_pkg::ST_OK;
                        ctl.ins_en  = 1'b1;
                        count_next  = CW'(count_reg + 1'b1);
                    end
                end
                else
                begin
                    rank_out_next = rss_pkg::RANK_OUT_BITS'(rank_reg);
                    if (XW'(rank_reg) >= XW'(count_reg))
                        status_next = rss_pkg::ST_RANGE;
                    else
                    begin
                        status_next = rss_pkg::ST_OK;
                        ctl.rem_en  = 1'b1;
                        count_next  = CW'(count_reg - 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            cmd_key_reg <= key;
            rank_reg    <= rank_in;
        end
        rank_out_reg <= rank_out_next;
        status_reg   <= status_next;
    end

    assign done     = done_reg;
    assign rank_out = rank_out_reg;
    assign status   = status_reg;

`ifndef ASSERT_OFF
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_APPLY)
        else $error("result without apply step");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_change_ok: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> done_reg && status_reg == rss_pkg::ST_OK)
        else $error("entry count changed without a successful transaction");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transaction accepted but not busy");
`endif

endmodule

[tb/sv/tb_top.sv]
// testbench for ranked_sorted_set_core: directed, random and fill-to-capacity command tests
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 17;
    localparam int KEY_MAX  = (1 << KEY_BITS) - 1;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [rss_pkg::RANK_OUT_BITS-1:0] rank_out;
        logic [rss_pkg::STATUS_BITS-1:0]   status;
    } set_result_t;

    logic                              clk     = 1'b0;
    logic                              rst_n   = 1'b0;
    logic                              start   = 1'b0;
    logic                              op      = rss_pkg::OP_INSERT;
    logic [KEY_BITS-1:0]               key     = '0;
    logic [rss_pkg::RANK_IN_BITS-1:0]  rank_in = '0;
    logic                              busy;
    logic                              done;
    logic [rss_pkg::RANK_OUT_BITS-1:0] rank_out;
    logic [rss_pkg::STATUS_BITS-1:0]   status;

    logic [KEY_BITS-1:0] set_keys[$];
    set_result_t         pending_results[$];
    int                  mismatch_count = 0;
    int                  status_count[4] = '{0, 0, 0, 0};
    int                  max_fill = 0;
    int                  zero_gap_run = 0;

    ranked_sorted_set_core #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .key(key),
        .rank_in(rank_in),
        .done(done),
        .rank_out(rank_out),
        .status(status)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR %s", $time, msg);
        mismatch_count++;
    endtask

    // updates the sorted set for one command and returns its result
    function automatic set_result_t apply_command(
        input logic                             cmd_op,
        input logic [KEY_BITS-1:0]              cmd_key,
        input logic [rss_pkg::RANK_IN_BITS-1:0] cmd_rank);
        set_result_t res;
        int          greater;
        bit          found;
        greater = 0;
        found = 1'b0;
        if (cmd_op == rss_pkg::OP_INSERT)
        begin
            foreach (set_keys[i])
            begin
                if (set_keys[i] > cmd_key)
                    greater++;
                else if (set_keys[i] == cmd_key)
                    found = 1'b1;
            end
            res.rank_out = rss_pkg::RANK_OUT_BITS'(greater);
            if (found)
                res.status = rss_pkg::ST_DUP;
            else if (set_keys.size() >= CAPACITY)
                res.status = rss_pkg::ST_FULL;
            else
            begin
                if (greater == set_keys.size())
                    set_keys.push_back(cmd_key);
                else
                    set_keys.insert(greater, cmd_key);
                res.status = rss_pkg::ST_OK;
            end
        end
        else
        begin
            res.rank_out = rss_pkg::RANK_OUT_BITS'(cmd_rank);
            if (int'(cmd_rank) >= set_keys.size())
                res.status = rss_pkg::ST_RANGE;
            else
            begin
                set_keys.delete(int'(cmd_rank));
                res.status = rss_pkg::ST_OK;
            end
        end
        if (set_keys.size() > max_fill)
            max_fill = set_keys.size();
        status_count[res.status]++;
        return res;
    endfunction

    task automatic send_cmd(input logic cmd_op, input logic [KEY_BITS-1:0] cmd_key,
                            input logic [rss_pkg::RANK_IN_BITS-1:0] cmd_rank);
        int gap;
        if (zero_gap_run > 0)
        begin
            gap = 0;
            zero_gap_run--;
        end
        else
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0)
                zero_gap_run = $urandom_range(8, 32);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        op      <= cmd_op;
        key     <= cmd_key;
        rank_in <= cmd_rank;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(apply_command(cmd_op, cmd_key, cmd_rank));
    endtask

    task automatic insert_key(input logic [KEY_BITS-1:0] k);
        send_cmd(rss_pkg::OP_INSERT, k,
                 rss_pkg::RANK_IN_BITS'($urandom_range(0, (1 << rss_pkg::RANK_IN_BITS) - 1)));
    endtask

    task automatic remove_rank(input int r);
        send_cmd(rss_pkg::OP_REMOVE, KEY_BITS'($urandom_range(0, KEY_MAX)),
                 rss_pkg::RANK_IN_BITS'(r));
    endtask

    // extremes, duplicates and out-of-range removes, ending with an empty set
    task automatic test_directed();
        remove_rank(0);
        remove_rank(1023);
        insert_key(0);
        insert_key(KEY_MAX);
        insert_key(17'h10000);
        insert_key(17'h10000);
        insert_key(0);
        insert_key(KEY_MAX);
        insert_key(1);
        insert_key(17'h15555);
        insert_key(17'h0aaaa);
        remove_rank(5);
        remove_rank(5);
        remove_rank(1023);
        remove_rank(0);
        repeat (4) remove_rank(0);
        remove_rank(0);
    endtask

    task automatic test_random_mix(input int n_items);
        int sz;
        int ins_pct;
        for (int i = 0; i < n_items; i++)
        begin
            sz = set_keys.size();
            ins_pct = (sz < 64) ? 70 : (sz < 800) ? 55 : 30;
            if ($urandom_range(0, 99) < ins_pct)
            begin
                if (sz > 0 && $urandom_range(0, 4) == 0)
                    insert_key(set_keys[$urandom_range(0, sz - 1)]);
                else
                    insert_key(KEY_BITS'($urandom_range(0, KEY_MAX)));
            end
            else
            begin
                if (sz > 0 && $urandom_range(0, 5) != 0)
                    remove_rank($urandom_range(0, sz - 1));
                else
                    remove_rank($urandom_range(0, 1023));
            end
        end
    endtask

    // fills the store, then hits full, duplicate-when-full and the top rank
    task automatic test_fill_to_capacity();
        if (set_keys.size() > 0 && set_keys[set_keys.size() - 1] == 0)
            remove_rank(set_keys.size() - 1);
        if (set_keys.size() > 0 && set_keys[0] == KEY_MAX)
            remove_rank(0);
        while (set_keys.size() < CAPACITY)
            insert_key(KEY_BITS'($urandom_range(1, KEY_MAX - 1)));
        insert_key(0);
        insert_key(KEY_MAX);
        insert_key(KEY_BITS'($urandom_range(1, KEY_MAX - 1)));
        insert_key(set_keys[CAPACITY / 2]);
        insert_key(set_keys[CAPACITY - 1]);
        remove_rank(CAPACITY - 1);
        insert_key(0);
        remove_rank(0);
        insert_key(KEY_MAX);
        remove_rank(1023);
        remove_rank(1023);
        remove_rank(0);
    endtask

    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result rank_out=%0d status=%0d",
                                          rank_out, status));
            else
            begin
                want = pending_results.pop_front();
                if (rank_out !== want.rank_out)
                    report_mismatch($sformatf("rank_out got %0d want %0d",
                                              rank_out, want.rank_out));
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d (rank_out %0d)",
                                              status, want.status, want.rank_out));
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(850);
        test_fill_to_capacity();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("transactions: %0d ok, %0d duplicate, %0d full, %0d rank out of range",
                 status_count[rss_pkg::ST_OK], status_count[rss_pkg::ST_DUP],
                 status_count[rss_pkg::ST_FULL], status_count[rss_pkg::ST_RANGE]);
        $display("largest set size reached: %0d of %0d", max_fill, CAPACITY);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

endmodule
